@@ design/rsk_pkg.sv @@
// Shared types and constants for the three-key record sorter.
// No dependencies; used by rsk_store and record_sorter_three_keys.
`timescale 1ns / 1ps
package rsk_pkg;
   localparam int ID_W    = 20;
   localparam int NAME_W  = 64;
   localparam int SCORE_W = 7;
   localparam int MODE_W  = 2;
   localparam int KIDX_W  = 6;   // arrival index bits in a key, covers 64 entries
   localparam int KEY_W   = NAME_W + SCORE_W + ID_W + KIDX_W;

   localparam logic [MODE_W-1:0] MODE_BY_ID   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BY_NAME = 2'd1;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [NAME_W-1:0]  name;
      logic [SCORE_W-1:0] score;
   } rec_type;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EMIT} state_type;

   // Total order: primary key, then id, then arrival index (keeps it stable).
   function automatic logic [KEY_W-1:0] make_key(input logic [MODE_W-1:0] mode,
                                                 input rec_type rec,
                                                 input logic [KIDX_W-1:0] idx);
      logic [KEY_W-1:0] k;
      begin
         k = '0;
         if (mode == MODE_BY_NAME) begin
            k = {rec.name, {SCORE_W{1'b0}}, rec.id, idx};
         end else if (mode[1]) begin
            k = {{NAME_W{1'b0}}, rec.score, rec.id, idx};
         end else begin
            k = {{NAME_W{1'b0}}, {SCORE_W{1'b0}}, rec.id, idx};
         end
         return k;
      end
   endfunction
endpackage

@@ design/rsk_store.sv @@
// Record store: one write port, one read port with registered read data.
// Depends on rsk_pkg.
`timescale 1ns / 1ps
module rsk_store import rsk_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  rec_type                  wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output rec_type                  rd_data
);
   rec_type mem [DEPTH];
   rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ design/record_sorter_three_keys.sv @@
// Three-key record sorter top level: load, then selection passes over the store.
// Depends on rsk_pkg and rsk_store.
//
//  channel  | handshake            | beat
//  req_     | start & !busy        | id, name, score, is_last
//  rsp_     | rsp_valid (1 cycle)  | id, name, score, last, overflowed
//  csr_     | csr_valid & ready    | sort_mode
//
// Loading accepts one record per cycle. After the last record, each of the N
// stored results takes one scan of the store (N reads, then the compare of the
// last read data and an emit), so a run of N records drains in N scans,
// set by the single read port of the store. busy is high during the drain.
// Reset is synchronous and clears control state; the store is not cleared.
// Results cannot be stalled.
`timescale 1ns / 1ps
module record_sorter_three_keys import rsk_pkg::*; #(
   parameter int MAX_RECORDS = 64,
   parameter int NAME_CHARS  = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [ID_W-1:0]    req_record_id,
   input  logic [NAME_W-1:0]  req_record_name,
   input  logic [SCORE_W-1:0] req_record_score,
   input  logic               req_is_last,
   output logic               rsp_valid,
   output logic [ID_W-1:0]    rsp_out_id,
   output logic [NAME_W-1:0]  rsp_out_name,
   output logic [SCORE_W-1:0] rsp_out_score,
   output logic               rsp_out_last,
   output logic               rsp_overflowed,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [MODE_W-1:0]  csr_sort_mode
);
   localparam int IW = $clog2(MAX_RECORDS);
   localparam int CW = $clog2(MAX_RECORDS + 1);

   state_type state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              drop_ff, drop_in;
   logic [MODE_W-1:0] mode_ff;
   logic [IW-1:0]     addr_ff, addr_in;
   logic              issued_ff, issued_in;
   logic              rdv_ff, rdv_in;
   logic [IW-1:0]     rdidx_ff;
   logic [KEY_W-1:0]  best_key_ff, best_key_in;
   rec_type           best_rec_ff, best_rec_in;
   logic              best_ok_ff, best_ok_in;
   logic [KEY_W-1:0]  prev_key_ff, prev_key_in;
   logic              have_prev_ff, have_prev_in;
   logic [CW-1:0]     emitted_ff, emitted_in;

   logic          accept, wr_en, last_emit;
   rec_type       wr_rec, rd_rec;
   logic [KEY_W-1:0] cand_key;
   logic [NAME_W-1:0] norm_name;
   logic          alive;

   // Zero-terminated name: bytes after the first zero byte, and bytes from index NAME_CHARS on, are cleared.
   always_comb begin
      norm_name = '0;
      alive     = 1'b1;
      for (int k = 0; k < 8; k++) begin
         if (req_record_name[NAME_W-1-8*k -: 8] == 8'd0 || k >= NAME_CHARS) begin
            alive = 1'b0;
         end
         if (alive) begin
            norm_name[NAME_W-1-8*k -: 8] = req_record_name[NAME_W-1-8*k -: 8];
         end
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign wr_en     = accept && (count_ff < CW'(MAX_RECORDS));
   assign wr_rec    = '{id: req_record_id, name: norm_name, score: req_record_score};

   rsk_store #(.DEPTH(MAX_RECORDS)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IW-1:0]),
      .wr_data (wr_rec),
      .rd_addr (addr_ff),
      .rd_data (rd_rec)
   );

   assign cand_key  = make_key(mode_ff, rd_rec, KIDX_W'(rdidx_ff));
   assign last_emit = (emitted_ff == count_ff - CW'(1));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      addr_in      = addr_ff;
      issued_in    = issued_ff;
      rdv_in       = 1'b0;
      best_key_in  = best_key_ff;
      best_rec_in  = best_rec_ff;
      best_ok_in   = best_ok_ff;
      prev_key_in  = prev_key_ff;
      have_prev_in = have_prev_ff;
      emitted_in   = emitted_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (wr_en) begin
                  count_in = count_ff + CW'(1);
               end else begin
                  drop_in = 1'b1;
               end
               if (req_is_last) begin
                  state_in     = ST_SCAN;
                  addr_in      = '0;
                  issued_in    = 1'b0;
                  best_ok_in   = 1'b0;
                  have_prev_in = 1'b0;
                  emitted_in   = '0;
               end
            end
         end
         ST_SCAN: begin
            if (!issued_ff) begin
               rdv_in = 1'b1;
               if (CW'(addr_ff) == count_ff - CW'(1)) begin
                  issued_in = 1'b1;
               end else begin
                  addr_in = addr_ff + IW'(1);
               end
            end
            if (rdv_ff) begin
               if ((!have_prev_ff || cand_key > prev_key_ff) &&
                   (!best_ok_ff || cand_key < best_key_ff)) begin
                  best_key_in = cand_key;
                  best_rec_in = rd_rec;
                  best_ok_in  = 1'b1;
               end
               if (issued_ff && CW'(rdidx_ff) == count_ff - CW'(1)) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            prev_key_in  = best_key_ff;
            have_prev_in = 1'b1;
            best_ok_in   = 1'b0;
            emitted_in   = emitted_ff + CW'(1);
            addr_in      = '0;
            issued_in    = 1'b0;
            if (last_emit) begin
               state_in = ST_IDLE;
               count_in = '0;
               drop_in  = 1'b0;
            end else begin
               state_in = ST_SCAN;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         mode_ff      <= MODE_BY_ID;
         issued_ff    <= 1'b0;
         rdv_ff       <= 1'b0;
         best_ok_ff   <= 1'b0;
         have_prev_ff <= 1'b0;
         emitted_ff   <= '0;
         addr_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         if (csr_valid && csr_ready) begin
            mode_ff <= csr_sort_mode;
         end
         issued_ff    <= issued_in;
         rdv_ff       <= rdv_in;
         best_ok_ff   <= best_ok_in;
         have_prev_ff <= have_prev_in;
         emitted_ff   <= emitted_in;
         addr_ff      <= addr_in;
      end
   end

   always_ff @(posedge clock) begin
      rdidx_ff    <= addr_ff;
      best_key_ff <= best_key_in;
      best_rec_ff <= best_rec_in;
      prev_key_ff <= prev_key_in;
   end

   assign rsp_valid      = (state_ff == ST_EMIT);
   assign rsp_out_id     = best_rec_ff.id;
   assign rsp_out_name   = best_rec_ff.name;
   assign rsp_out_score  = best_rec_ff.score;
   assign rsp_out_last   = rsp_valid && last_emit;
   assign rsp_overflowed = drop_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_RECORDS)) else $error("record count over capacity");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_out_last |=> !busy) else $error("busy after final result");
   a_emit_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> best_ok_ff) else $error("result emitted without a candidate");
   a_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && have_prev_ff) |-> best_key_ff > prev_key_ff)
      else $error("results out of order");
`endif
endmodule

@@ bench/record_sorter_three_keys_chk.sv @@
// Checker for the three-key record sorter: watches the load, config and
// result channels, predicts sorted output runs and compares. Uses rsk_pkg.
`timescale 1ns / 1ps
module record_sorter_three_keys_chk import rsk_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [ID_W-1:0]    req_record_id,
   input  logic [NAME_W-1:0]  req_record_name,
   input  logic [SCORE_W-1:0] req_record_score,
   input  logic               req_is_last,
   input  logic               rsp_valid,
   input  logic [ID_W-1:0]    rsp_out_id,
   input  logic [NAME_W-1:0]  rsp_out_name,
   input  logic [SCORE_W-1:0] rsp_out_score,
   input  logic               rsp_out_last,
   input  logic               rsp_overflowed,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [MODE_W-1:0]  csr_sort_mode,
   output int                 fail_count,
   output int                 pending
);
   localparam int DEPTH = 64;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [NAME_W-1:0]  name;
      logic [SCORE_W-1:0] score;
      logic               last;
      logic               ovf;
   } sorted_beat_type;

   sorted_beat_type  sorted_q[$];
   rec_type          held[DEPTH];
   int               held_count;
   logic             dropped;
   logic [MODE_W-1:0] mode;

   assign pending = sorted_q.size();

   function automatic logic [NAME_W-1:0] trim_name(input logic [NAME_W-1:0] raw);
      logic [NAME_W-1:0] r;
      r = '0;
      for (int k = 0; k < 8; k++) begin
         if (raw[63-8*k -: 8] == 8'd0) break;
         r[63-8*k -: 8] = raw[63-8*k -: 8];
      end
      return r;
   endfunction

   function automatic bit goes_first(input rec_type a, input rec_type b,
                                     input logic [MODE_W-1:0] m);
      if (m == MODE_BY_NAME && a.name != b.name) return a.name < b.name;
      if (m[1] && a.score != b.score) return a.score < b.score;
      return a.id < b.id;
   endfunction

   task automatic emit_run();
      int order[DEPTH];
      int j;
      sorted_beat_type b;
      for (int i = 0; i < held_count; i++) begin
         j = i;
         while (j > 0 && goes_first(held[i], held[order[j-1]], mode)) begin
            order[j] = order[j-1];
            j--;
         end
         order[j] = i;
      end
      for (int i = 0; i < held_count; i++) begin
         b.id    = held[order[i]].id;
         b.name  = held[order[i]].name;
         b.score = held[order[i]].score;
         b.last  = (i == held_count - 1);
         b.ovf   = dropped;
         sorted_q.push_back(b);
      end
      held_count = 0;
      dropped    = 1'b0;
   endtask

   always @(posedge clock) begin
      sorted_beat_type exp_b;
      if (reset) begin
         mode       <= MODE_BY_ID;
         held_count = 0;
         dropped    = 1'b0;
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) mode <= csr_sort_mode;
         if (rsp_valid) begin
            if (sorted_q.size() == 0) begin
               $display("%0t: unexpected beat id=%0d", $time, rsp_out_id);
               fail_count++;
            end else begin
               exp_b = sorted_q.pop_front();
               if ({rsp_out_id, rsp_out_name, rsp_out_score, rsp_out_last,
                    rsp_overflowed} !== exp_b) begin
                  $display("%0t: mismatch exp id=%0d name=%h score=%0d last=%b ovf=%b",
                           $time, exp_b.id, exp_b.name, exp_b.score, exp_b.last,
                           exp_b.ovf);
                  $display("%0t:          got id=%0d name=%h score=%0d last=%b ovf=%b",
                           $time, rsp_out_id, rsp_out_name, rsp_out_score,
                           rsp_out_last, rsp_overflowed);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            if (held_count < DEPTH) begin
               held[held_count].id    = req_record_id;
               held[held_count].name  = trim_name(req_record_name);
               held[held_count].score = req_record_score;
               held_count++;
            end else begin
               dropped = 1'b1;
            end
            if (req_is_last) emit_run();
         end
      end
   end
endmodule

@@ bench/record_sorter_three_keys_tb.sv @@
// Top of the record sorter bench: clock, reset, load and mode stimulus, verdict.
// Depends on rsk_pkg, record_sorter_three_keys and record_sorter_three_keys_chk.
`timescale 1ns / 1ps
module record_sorter_three_keys_tb;
   import rsk_pkg::*;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [ID_W-1:0]    req_record_id = '0;
   logic [NAME_W-1:0]  req_record_name = '0;
   logic [SCORE_W-1:0] req_record_score = '0;
   logic               req_is_last = 1'b0;
   logic               rsp_valid;
   logic [ID_W-1:0]    rsp_out_id;
   logic [NAME_W-1:0]  rsp_out_name;
   logic [SCORE_W-1:0] rsp_out_score;
   logic               rsp_out_last;
   logic               rsp_overflowed;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [MODE_W-1:0]  csr_sort_mode = '0;
   int                 fail_count;
   int                 pending;
   int                 idle_pct;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   record_sorter_three_keys dut (.*);
   record_sorter_three_keys_chk chk (.*);

   initial begin
      #60ms;
      $display("TEST FAILED");
      $finish;
   end

   function automatic logic [NAME_W-1:0] rand_name();
      logic [NAME_W-1:0] n;
      int len;
      n = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: ;  // raw, possibly with embedded zeros
         1: begin
            len = $urandom_range(0, 8);
            for (int k = 0; k < 8; k++)
               n[63-8*k -: 8] = (k < len) ? 8'($urandom_range(97, 100)) : 8'd0;
         end
         2: n = {8'($urandom_range(65, 66)), 56'd0};
         default: n = {$urandom_range(0, 1) ? 8'hff : 8'h41, 8'h00, $urandom, 16'd0};
      endcase
      return n;
   endfunction

   // One load beat, after random idling; rand_run narrows id/score ranges sometimes to force key ties.
   // start stays high after the beat; the next beat or set_mode moves it.
   task automatic load_beat(input logic [ID_W-1:0] id, input logic [NAME_W-1:0] nm,
                            input logic [SCORE_W-1:0] sc, input logic last);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start            <= 1'b1;
      req_record_id    <= id;
      req_record_name  <= nm;
      req_record_score <= sc;
      req_is_last      <= last;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic rand_run(input int n);
      logic [ID_W-1:0] id;
      logic [SCORE_W-1:0] sc;
      for (int i = 0; i < n; i++) begin
         id = $urandom_range(0, 1) ? ID_W'($urandom_range(0, 7)) : ID_W'($urandom);
         sc = $urandom_range(0, 1) ? SCORE_W'($urandom_range(0, 3)) : SCORE_W'($urandom);
         load_beat(id, rand_name(), sc, i == n - 1);
      end
   endtask

   task automatic set_mode(input logic [MODE_W-1:0] m);
      start <= 1'b0;
      @(posedge clock);
      while (busy || pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_valid     <= 1'b1;
      csr_sort_mode <= m;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      idle_pct = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: extremes, ties, names with embedded zero, single-record run
      set_mode(2'd0);
      load_beat(20'hfffff, '1, 7'h7f, 1'b0);
      load_beat(20'd0, '0, 7'd0, 1'b0);
      load_beat(20'd999999, 64'h4100_4200_0000_0000, 7'd100, 1'b0);
      load_beat(20'd5, 64'h4142_4344_4546_4748, 7'd100, 1'b1);
      load_beat(20'd7, 64'h4100_0000_0000_0000, 7'd3, 1'b1);
      set_mode(2'd1);
      load_beat(20'd9, 64'h4100_0000_0000_0000, 7'd1, 1'b0);
      load_beat(20'd2, 64'h41ff_0000_0000_0000, 7'd1, 1'b0);
      load_beat(20'd4, 64'h4100_5500_0000_0000, 7'd2, 1'b0);
      load_beat(20'd4, 64'h4100_0000_0000_0000, 7'd0, 1'b1);
      set_mode(2'd2);
      load_beat(20'd3, 64'h61, 7'd5, 1'b0);
      load_beat(20'd1, 64'h62, 7'd5, 1'b0);
      load_beat(20'd1, 64'h63, 7'd5, 1'b0);
      load_beat(20'd8, 64'h64, 7'd0, 1'b1);
      set_mode(2'd3);
      load_beat(20'd6, '1, 7'd9, 1'b0);
      load_beat(20'd2, '0, 7'd9, 1'b0);
      load_beat(20'd1, '1, 7'd127, 1'b1);
      // store overflow: 66 records, the last one dropped too
      set_mode(2'd0);
      rand_run(66);
      // random runs across modes and idling phases
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = (ph == 1) ? 56 : (ph == 3) ? 7 : 0;
         for (int r = 0; r < 6; r++) begin
            if ($urandom_range(0, 2) == 0) set_mode(MODE_W'($urandom_range(0, 3)));
            rand_run($urandom_range(1, 8));
         end
      end
      set_mode(2'd1);
      rand_run(64);
      start <= 1'b0;
      @(posedge clock);
      while (busy || pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule
